/* sv/apg_pkg.sv */
package apg_pkg;

  // Field and datapath widths
  localparam int CoordW = 16;
  localparam int HalfW  = 12;
  localparam int DiffW  = 17;  // start-to-tip difference
  localparam int TermW  = 24;  // c10*dx + m10*dy
  localparam int ProdW  = 36;  // term * h
  localparam int NumW   = 44;  // divider numerator magnitude
  localparam int DenW   = 29;  // 10 * length * 256
  localparam int RootW  = 25;
  localparam int RadW   = 50;
  localparam int SumW   = 46;
  localparam int CntW   = 6;   // divider step counter

  localparam int NumVert = 8;

  // Register map (word index)
  localparam logic [1:0] REG_CX = 2'd0;
  localparam logic [1:0] REG_CY = 2'd1;
  localparam logic [1:0] REG_HW = 2'd2;

  localparam logic [CoordW-1:0] CX_RESET = 16'd4800;
  localparam logic [CoordW-1:0] CY_RESET = 16'd4800;
  localparam logic [HalfW-1:0]  HW_RESET = 12'd48;

  // Arrow outline in tenths of h: local x = e*L - c10*h/10, local y = m10*h/10
  localparam logic signed [7:0] C10 [NumVert] = '{
    8'sd0, 8'sd0, 8'sd50, 8'sd70, 8'sd0, 8'sd70, 8'sd50, 8'sd0
  };
  localparam logic signed [7:0] M10 [NumVert] = '{
    8'sd0, 8'sd7, 8'sd10, 8'sd40, 8'sd0, -8'sd40, -8'sd10, -8'sd7
  };
  localparam logic [NumVert-1:0] EMASK = 8'b0111_1100;

  typedef struct packed {
    logic signed [DiffW-1:0]  dx;
    logic signed [DiffW-1:0]  dy;
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic [HalfW-1:0]         h;
    logic [DenW-1:0]          den;
    logic                     degen;
  } job_t;

endpackage

/* sv/arrow_polygon_generator_top.sv */
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_stall_o   | end_x_i, end_y_i
// out     | output    | out_valid_o/out_stall_i | vertex_x_o, vertex_y_o, vertex_index_o,
//         |           |                      | last_o, degenerate_o
// cfg     | APB       | psel/penable/pready  | paddr, pwdata, prdata
//
// Front: one tip at a time (17x17 squares, then a 25-step root of the
// squared length). Back: each vertex waits on the two 44-step
// radix-2 dividers (x and y run side by side); an arrow is eight vertices.
// A two-entry queue lets the front take the next tip while the back works.
// The output register frees the back as soon as a vertex is loaded.
// Reset is asynchronous, active low; registers return to 4800/4800/48.
// No clearing pass after reset.
module arrow_polygon_generator_top
  import apg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] vertex_x_o,
  output logic signed [CoordW-1:0] vertex_y_o,
  output logic [2:0]               vertex_index_o,
  output logic                     last_o,
  output logic                     degenerate_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic signed [CoordW-1:0] center_x_q, center_y_q;
  logic [HalfW-1:0]         half_width_q;
  logic [1:0]               reg_idx;
  logic                     wr_en;

  logic push, pop, q_full, q_empty;
  job_t job_in, job_out;

  // Config registers: written on the access phase of an APB write
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= CX_RESET;
      center_y_q   <= CY_RESET;
      half_width_q <= HW_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CX:  center_x_q   <= pwdata[CoordW-1:0];
        REG_CY:  center_y_q   <= pwdata[CoordW-1:0];
        REG_HW:  half_width_q <= pwdata[HalfW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CX:  prdata = {16'h0000, center_x_q};
      REG_CY:  prdata = {16'h0000, center_y_q};
      REG_HW:  prdata = {20'h00000, half_width_q};
      default: prdata = '0;
    endcase
  end

  // Front: difference, squared length, root -> job
  apg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .end_x_i     (end_x_i),
    .end_y_i     (end_y_i),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .half_width_i(half_width_q),
    .full_i      (q_full),
    .push_o      (push),
    .job_o       (job_in)
  );

  apg_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_in),
    .pop_i  (pop),
    .data_o (job_out),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  // Back: eight vertices per job, rotate/scale by divide, saturate
  apg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_out),
    .empty_i       (q_empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .vertex_x_o    (vertex_x_o),
    .vertex_y_o    (vertex_y_o),
    .vertex_index_o(vertex_index_o),
    .last_o        (last_o),
    .degenerate_o  (degenerate_o)
  );

`ifndef SYNTHESIS
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (vertex_index_o == 3'd7)))
    else $error("last flag does not match vertex index");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("job queue underflow");

  a_degen_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o && vertex_index_o == 3'd0) |->
      (vertex_x_o == center_x_q && vertex_y_o == center_y_q))
    else $error("degenerate arrow does not start at the center");
`endif

endmodule

/* sv/apg_front.sv */
module apg_front
  import apg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic [HalfW-1:0]         half_width_i,
  input  logic                     full_i,
  output logic                     push_o,
  output job_t                     job_o
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_SQ   = 2'd1;
  localparam logic [1:0] F_ROOT = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;

  logic signed [DiffW-1:0]  dx_q, dy_q;
  logic signed [CoordW-1:0] cx_q, cy_q;
  logic [HalfW-1:0]         h_q;
  logic [RadW-1:0]          rad_q, rad_d;
  logic [RootW+2:0]         rem_q, rem_d;
  logic [RootW-1:0]         root_q, root_d;
  logic                     degen_q, degen_d;

  logic signed [2*DiffW-1:0] sqx, sqy;
  logic [32:0]               sum_sq;
  logic [RootW+2:0]          rem_sh, trial;
  logic [DenW-1:0]           den;
  logic                      accept;

  assign in_stall_o = (state_q != F_IDLE);
  assign accept     = in_valid_i && (state_q == F_IDLE);

  assign sqx    = dx_q * dx_q;
  assign sqy    = dy_q * dy_q;
  assign sum_sq = {1'b0, sqx[31:0]} + {1'b0, sqy[31:0]};

  // one root digit per cycle
  assign rem_sh = {rem_q[RootW:0], rad_q[RadW-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};

  assign den = degen_q ? DenW'(10) : ({root_q, 3'b000} + {3'b000, root_q, 1'b0});

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    degen_d = degen_q;
    case (state_q)
      F_IDLE: begin
        if (accept) state_d = F_SQ;
      end
      F_SQ: begin
        rad_d   = {1'b0, sum_sq, 16'h0000};
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        degen_d = (dx_q == '0) && (dy_q == '0);
        state_d = F_ROOT;
      end
      F_ROOT: begin
        rad_d = {rad_q[RadW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(RootW - 1)) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) state_d = F_IDLE;
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dx_q <= DiffW'(end_x_i) - DiffW'(center_x_i);
      dy_q <= DiffW'(end_y_i) - DiffW'(center_y_i);
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      h_q  <= half_width_i;
    end
    rad_q   <= rad_d;
    rem_q   <= rem_d;
    root_q  <= root_d;
    degen_q <= degen_d;
  end

  assign push_o = (state_q == F_PUSH) && !full_i;

  always_comb begin
    job_o.dx    = dx_q;
    job_o.dy    = dy_q;
    job_o.cx    = cx_q;
    job_o.cy    = cy_q;
    job_o.h     = h_q;
    job_o.den   = den;
    job_o.degen = degen_q;
  end

endmodule

/* sv/apg_queue.sv */
module apg_queue
  import apg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  input  logic pop_i,
  output job_t data_o,
  output logic full_o,
  output logic empty_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 2'd1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

/* sv/apg_div.sv */
module apg_div
  import apg_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            busy_o,
  output logic [NumW-1:0] quot_o
);

  // restoring divider, one quotient bit per cycle
  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW-1:0] den_q;
  logic [DenW-1:0] rem_q;
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   trial;
  logic            fits;

  assign trial = {rem_q, quo_q[NumW-1]};
  assign fits  = (trial >= {1'b0, den_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(NumW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= fits ? DenW'(trial - {1'b0, den_q}) : DenW'(trial);
      quo_q <= {quo_q[NumW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

/* sv/apg_back.sv */
module apg_back
  import apg_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  job_t                     job_i,
  input  logic                     empty_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] vertex_x_o,
  output logic signed [CoordW-1:0] vertex_y_o,
  output logic [2:0]               vertex_index_o,
  output logic                     last_o,
  output logic                     degenerate_o
);

  localparam logic [2:0] B_IDLE  = 3'd0;
  localparam logic [2:0] B_MUL   = 3'd1;
  localparam logic [2:0] B_SCALE = 3'd2;
  localparam logic [2:0] B_DIV   = 3'd3;
  localparam logic [2:0] B_OUT   = 3'd4;

  logic [2:0] state_q;
  logic [2:0] k_q;
  job_t       job_q;

  logic signed [TermW-1:0] tx_q, ty_q;
  logic                    negx_q, negy_q;

  logic signed [TermW:0]   tmx, tmy;
  logic signed [ProdW-1:0] px, py;
  logic signed [HalfW:0]   hs;
  logic signed [NumW-1:0]  nx, ny;
  logic [NumW-1:0]         magx, magy, numx, numy, qx, qy;
  logic                    busy_x, busy_y, start, load;
  logic signed [SumW-1:0]  sumx, sumy, ex, ey;

  logic                     out_valid_q;
  logic signed [CoordW-1:0] vx_q, vy_q;
  logic [2:0]               idx_q;
  logic                     last_q, degen_q;

  function automatic logic signed [CoordW-1:0] sat(input logic signed [SumW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > SumW'(32767))       r = 16'sh7fff;
    else if (v < -SumW'(32768)) r = 16'sh8000;
    else                        r = v[CoordW-1:0];
    return r;
  endfunction

  assign tmx = C10[k_q] * job_q.dx + M10[k_q] * job_q.dy;
  assign tmy = C10[k_q] * job_q.dy - M10[k_q] * job_q.dx;

  assign hs = {1'b0, job_q.h};
  assign px = tx_q * hs;
  assign py = ty_q * hs;
  assign nx = job_q.degen ? NumW'(px) : {px, 8'h00};
  assign ny = job_q.degen ? NumW'(py) : {py, 8'h00};
  assign magx = nx[NumW-1] ? NumW'(-nx) : NumW'(nx);
  assign magy = ny[NumW-1] ? NumW'(-ny) : NumW'(ny);
  // round half away from zero: bias the magnitude by den/2
  assign numx = magx + NumW'(job_q.den >> 1);
  assign numy = magy + NumW'(job_q.den >> 1);
  assign start = (state_q == B_SCALE);

  apg_div u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .num_i  (numx),
    .den_i  (job_q.den),
    .busy_o (busy_x),
    .quot_o (qx)
  );

  apg_div u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .num_i  (numy),
    .den_i  (job_q.den),
    .busy_o (busy_y),
    .quot_o (qy)
  );

  assign ex   = EMASK[k_q] ? SumW'(job_q.dx) : '0;
  assign ey   = EMASK[k_q] ? SumW'(job_q.dy) : '0;
  assign sumx = SumW'(job_q.cx) + ex
              + (negx_q ? $signed(SumW'(qx)) : -$signed(SumW'(qx)));
  assign sumy = SumW'(job_q.cy) + ey
              + (negy_q ? $signed(SumW'(qy)) : -$signed(SumW'(qy)));

  assign pop_o = (state_q == B_IDLE) && !empty_i;
  assign load  = (state_q == B_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (!empty_i) begin
            state_q <= B_MUL;
            k_q     <= '0;
          end
        end
        B_MUL:   state_q <= B_SCALE;
        B_SCALE: state_q <= B_DIV;
        B_DIV: begin
          if (!busy_x && !busy_y) state_q <= B_OUT;
        end
        B_OUT: begin
          if (load) begin
            k_q     <= k_q + 3'd1;
            state_q <= (k_q == 3'(NumVert - 1)) ? B_IDLE : B_MUL;
          end
        end
        default: state_q <= B_IDLE;
      endcase
      if (load)                  out_valid_q <= 1'b1;
      else if (!out_stall_i)     out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    if (state_q == B_MUL) begin
      tx_q <= job_q.degen ? TermW'(C10[k_q]) : tmx[TermW-1:0];
      ty_q <= job_q.degen ? -TermW'(M10[k_q]) : tmy[TermW-1:0];
    end
    if (start) begin
      negx_q <= nx[NumW-1];
      negy_q <= ny[NumW-1];
    end
    if (load) begin
      vx_q    <= sat(sumx);
      vy_q    <= sat(sumy);
      idx_q   <= k_q;
      last_q  <= (k_q == 3'(NumVert - 1));
      degen_q <= job_q.degen;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign vertex_x_o     = vx_q;
  assign vertex_y_o     = vy_q;
  assign vertex_index_o = idx_q;
  assign last_o         = last_q;
  assign degenerate_o   = degen_q;

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import apg_pkg::*;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  // DUT interface
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic signed [CoordW-1:0] end_x_i = '0;
  logic signed [CoordW-1:0] end_y_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [CoordW-1:0] vertex_x_o;
  logic signed [CoordW-1:0] vertex_y_o;
  logic [2:0]               vertex_index_o;
  logic                     last_o;
  logic                     degenerate_o;
  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [3:0]               paddr = '0;
  logic [31:0]              pwdata = '0;
  logic [31:0]              prdata;
  logic                     pready;

  arrow_polygon_generator_top u_top (.*);

  // Expected vertex record
  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic [2:0]               idx;
    logic                     last;
    logic                     degen;
  } vertex_t;

  vertex_t vertex_q[$];

  // Testbench copy of the register file
  logic signed [15:0] arrow_cx;
  logic signed [15:0] arrow_cy;
  logic [11:0]        arrow_hw;

  int errors = 0;
  int arrows_sent = 0;
  int vertices_seen = 0;
  int degen_seen = 0;
  int idle_cycles = 0;
  bit drain_done = 0;
  localparam int WatchdogLimit = 20000;

  // Outline table in tenths of h
  localparam int OutE[8]   = '{0, 0, 1, 1, 1, 1, 1, 0};
  localparam int OutC10[8] = '{0, 0, 50, 70, 0, 70, 50, 0};
  localparam int OutM10[8] = '{0, 7, 10, 40, 0, -40, -10, -7};

  // Integer square root (floor)
  function automatic longint isqrt(longint n);
    longint lo, hi, mid;
    begin
      lo = 0;
      hi = 64'd4294967296;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        if (mid * mid <= n) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    end
  endfunction

  // Division rounded to nearest, halves away from zero
  function automatic longint round_div(longint num, longint den);
    longint mag, q;
    begin
      mag = (num < 0) ? -num : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -q : q;
    end
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // Arrow outline prediction: eight vertices per tip
  task automatic predict_arrow(input logic signed [15:0] tx, input logic signed [15:0] ty);
    longint cx, cy, h, dx, dy, den, x, y;
    bit degen;
    vertex_t v;
    begin
      cx = arrow_cx;
      cy = arrow_cy;
      h = arrow_hw;
      dx = longint'(tx) - cx;
      dy = longint'(ty) - cy;
      degen = (dx == 0) && (dy == 0);
      den = degen ? 0 : 10 * isqrt((dx * dx + dy * dy) * 65536);
      for (int k = 0; k < 8; k++) begin
        if (degen) begin
          x = cx - (OutC10[k] * h) / 10;
          y = cy + round_div(OutM10[k] * h, 10);
        end else begin
          x = cx + (OutE[k] ? dx : 0)
              - round_div(h * (OutC10[k] * dx + OutM10[k] * dy) * 256, den);
          y = cy + (OutE[k] ? dy : 0)
              - round_div(h * (OutC10[k] * dy - OutM10[k] * dx) * 256, den);
        end
        v.x = clamp16(x);
        v.y = clamp16(y);
        v.idx = k[2:0];
        v.last = (k == 7);
        v.degen = degen;
        vertex_q.push_back(v);
      end
    end
  endtask

  // Random gap length: mostly short, occasionally long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // APB register write: setup then access phase
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_CX: arrow_cx = val[15:0];
      REG_CY: arrow_cy = val[15:0];
      REG_HW: arrow_hw = val[11:0];
      default: ;
    endcase
  endtask

  // Send one tip point and queue its predicted outline; valid drops only
  // when a gap follows, so back-to-back tips keep it high
  task automatic send_tip(input logic signed [15:0] tx, input logic signed [15:0] ty);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    end_x_i <= tx;
    end_y_i <= ty;
    predict_arrow(tx, ty);
    do @(posedge clk_i); while (in_stall_o);
    arrows_sent++;
  endtask

  // Wait for the block to drain before touching registers
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_arrow(input logic signed [15:0] cx, input logic signed [15:0] cy,
                           input logic [11:0] hw);
    wait_drained();
    reg_write(REG_CX, {{16{cx[15]}}, cx});
    reg_write(REG_CY, {{16{cy[15]}}, cy});
    reg_write(REG_HW, {20'd0, hw});
  endtask

  // Receiver: random stalls, compare each vertex transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        vertices_seen++;
        if (vertex_q.size() == 0) begin
          $error("unexpected vertex transfer x=%0d y=%0d", vertex_x_o, vertex_y_o);
          errors++;
        end else begin
          automatic vertex_t e = vertex_q.pop_front();
          if (e.degen) degen_seen++;
          if (vertex_x_o !== e.x) begin
            $error("vertex_x expected %0d actual %0d", e.x, vertex_x_o);
            errors++;
          end
          if (vertex_y_o !== e.y) begin
            $error("vertex_y expected %0d actual %0d", e.y, vertex_y_o);
            errors++;
          end
          if (vertex_index_o !== e.idx) begin
            $error("vertex_index expected %0d actual %0d", e.idx, vertex_index_o);
            errors++;
          end
          if (last_o !== e.last) begin
            $error("last expected %0d actual %0d", e.last, last_o);
            errors++;
          end
          if (degenerate_o !== e.degen) begin
            $error("degenerate expected %0d actual %0d", e.degen, degenerate_o);
            errors++;
          end
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < 25) ? 1'b1 : 1'b0;
    end
  end

  // Watchdog: cycles with no transfer on either stream channel and no APB access
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit && !drain_done) begin
      $display("watchdog: no transfer for %0d cycles", WatchdogLimit);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Register defaults, then tip on start
  task automatic test_reset_defaults();
    send_tip(16'sd4800, 16'sd4800);
    send_tip(16'sd6400, 16'sd4800);
    send_tip(16'sd4800, 16'sd3200);
  endtask

  // Extreme fields and saturation
  task automatic test_extremes();
    set_arrow(16'sh8000, 16'sh8000, 12'hfff);
    send_tip(16'sh7fff, 16'sh7fff);
    send_tip(16'sh8000, 16'sh8000);
    send_tip(16'sh8000, 16'sh7fff);
    send_tip(16'sh8001, 16'sh8000);
    set_arrow(16'sh7fff, 16'sh7fff, 12'h000);
    send_tip(16'sh8000, 16'sh8000);
    send_tip(16'sh7fff, 16'sh7fff);
    send_tip(16'sh7fff, 16'sh7ffe);
    set_arrow(16'sd0, 16'sd0, 12'hfff);
    send_tip(16'sd0, 16'sd0);
    send_tip(16'sd1, 16'sd0);
    send_tip(16'sd0, -16'sd1);
    send_tip(-16'sd1, -16'sd1);
    send_tip(16'sh7fff, 16'sd0);
    send_tip(16'sd0, 16'sh8000);
  endtask

  // Random tips under a few register settings
  task automatic test_random_arrows();
    logic signed [15:0] tx, ty;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_arrow(16'sd0, 16'sd0, 12'd48);
        1: set_arrow(16'($urandom), 16'($urandom), 12'($urandom));
        2: set_arrow(16'sd4800, -16'sd4800, 12'd1);
        default: set_arrow(16'($urandom), 16'($urandom), 12'($urandom_range(0, 4095)));
      endcase
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(0, 9))
          0: begin tx = arrow_cx; ty = arrow_cy; end
          1, 2: begin
            tx = 16'(arrow_cx + $signed($urandom_range(0, 64)) - 32);
            ty = 16'(arrow_cy + $signed($urandom_range(0, 64)) - 32);
          end
          default: begin tx = 16'($urandom); ty = 16'($urandom); end
        endcase
        send_tip(tx, ty);
      end
    end
  endtask

  initial begin
    arrow_cx = CX_RESET;
    arrow_cy = CY_RESET;
    arrow_hw = HW_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_extremes();
    test_random_arrows();

    // Drain remaining vertices, then a short settle
    in_valid_i <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    drain_done = 1;

    $display("covered %0d arrows, %0d vertices (%0d degenerate) across 10 settings",
             arrows_sent, vertices_seen, degen_seen);
    if (errors == 0 && vertex_q.size() == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
